// ----- rtl/core/c3f_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_pkg: shared types and constants of the 3x3 clamped filter
// Field widths, register indexes, fixed-point sizes and the result queue
// geometry used by the filter core and its datapath.
// ----------------------------------------------------------------------------
package c3f_pkg;

    // pixel and size fields
    localparam int PIX_W       = 8;
    localparam int PIX_MAX     = 255;
    localparam int SIZE_W      = 11;
    localparam int SIZE_RESET  = 1024;
    localparam int OUTER_LIMIT = 1024;
    localparam int OPOS_W      = 11;    // holds OUTER_LIMIT + 1
    localparam int BORDER      = 2;     // first interior window position

    // kernel geometry
    localparam int COEF_W   = 16;       // signed Q8.8
    localparam int KROWS    = 3;
    localparam int KCOLS    = 3;
    localparam int WIN_TAPS = KROWS * KCOLS;
    localparam int KROW_W   = KCOLS * COEF_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

    // fixed-point datapath
    localparam int FRAC_W = 8;
    localparam int PROD_W = PIX_W + 1 + COEF_W;   // unsigned pixel x signed coef
    localparam int SUM_W  = 20;                   // |sum| < 9 * 2^15
    localparam int ACC_W  = SUM_W + FRAC_W + 1;

    // result queue, depth is a power of two so pointers wrap naturally
    localparam int FIFO_DEPTH = 16;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [WIN_TAPS-1:0][PIX_W-1:0] t_win;
    typedef logic [KROWS-1:0][KROW_W-1:0]   t_kernel;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/c3f_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_if: stream channels of the 3x3 clamped filter
// Pixel input, filtered result output and register write channel, each a
// valid/ready handshake that moves one item per accepting edge.
// ----------------------------------------------------------------------------

interface c3f_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [c3f_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface c3f_result_if;
    logic                      valid;
    logic                      ready;
    logic [c3f_pkg::PIX_W-1:0] out_pixel;
    logic                      frame_last;

    modport source (output valid, output out_pixel, output frame_last, input ready);
    modport sink   (input valid, input out_pixel, input frame_last, output ready);
endinterface

interface c3f_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [c3f_pkg::CFG_IDX_W-1:0]  index;
    logic [c3f_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/c3f_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module c3f_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1026
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/c3f_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_mac: kernel datapath of the 3x3 clamped filter
// Nine parallel pixel x coefficient products, then the truncating running
// sum over three stages of three taps, then the clamp to 0..255.
// Registered output, no stall.
// ----------------------------------------------------------------------------
module c3f_mac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  c3f_pkg::t_ctl             i_ctl,
    input  c3f_pkg::t_win             i_win,
    input  c3f_pkg::t_kernel          i_kernel,
    output c3f_pkg::t_ctl             o_ctl,
    output logic [c3f_pkg::PIX_W-1:0] o_pixel
);
    import c3f_pkg::*;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam t_sum SUM_MAX = t_sum'(PIX_MAX);

    // sum = trunc((sum * 256 + prod) / 256), rounding toward zero
    function automatic t_sum f_tap(input t_sum sum, input t_prod prod);
        t_acc t;
        t_acc q;
        t = (t_acc'(sum) <<< FRAC_W) + t_acc'(prod);
        q = t >>> FRAC_W;
        if (t[ACC_W-1] && (t[FRAC_W-1:0] != '0)) begin
            q = q + t_acc'(1);
        end
        return q[SUM_W-1:0];
    endfunction

    t_prod w_prod  [WIN_TAPS];
    t_prod r_prod1 [WIN_TAPS];
    t_prod r_prod2 [2*KCOLS];
    t_prod r_prod3 [KCOLS];
    t_sum  w_sum2;
    t_sum  w_sum3;
    t_sum  w_sum4;
    t_sum  r_sum2;
    t_sum  r_sum3;
    t_ctl  r_ctl1;
    t_ctl  r_ctl2;
    t_ctl  r_ctl3;
    t_ctl  r_ctl4;
    logic [PIX_W-1:0] n_pixel;
    logic [PIX_W-1:0] r_pixel;

    // products: zero-extended pixel times signed coefficient
    always_comb begin
        for (int r = 0; r < KROWS; r++) begin
            for (int c = 0; c < KCOLS; c++) begin
                w_prod[r*KCOLS+c] = t_prod'(signed'({1'b0, i_win[r*KCOLS+c]}))
                                  * t_prod'(signed'(i_kernel[r][c*COEF_W +: COEF_W]));
            end
        end
    end

    // running sum, one kernel row per stage
    always_comb begin
        w_sum2 = '0;
        for (int k = 0; k < KCOLS; k++) begin
            w_sum2 = f_tap(w_sum2, r_prod1[k]);
        end
    end

    always_comb begin
        w_sum3 = r_sum2;
        for (int k = 0; k < KCOLS; k++) begin
            w_sum3 = f_tap(w_sum3, r_prod2[k]);
        end
    end

    always_comb begin
        w_sum4 = r_sum3;
        for (int k = 0; k < KCOLS; k++) begin
            w_sum4 = f_tap(w_sum4, r_prod3[k]);
        end
    end

    // clamp to the pixel range
    always_comb begin
        if (w_sum4[SUM_W-1]) begin
            n_pixel = '0;
        end else if (w_sum4 > SUM_MAX) begin
            n_pixel = PIX_W'(PIX_MAX);
        end else begin
            n_pixel = w_sum4[PIX_W-1:0];
        end
    end

    // control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    // data pipeline
    always_ff @(posedge i_clk) begin
        r_prod1 <= w_prod;
        r_sum2  <= w_sum2;
        for (int k = 0; k < 2*KCOLS; k++) begin
            r_prod2[k] <= r_prod1[k+KCOLS];
        end
        r_sum3  <= w_sum3;
        for (int k = 0; k < KCOLS; k++) begin
            r_prod3[k] <= r_prod2[k+KCOLS];
        end
        r_pixel <= n_pixel;
    end

    assign o_ctl   = r_ctl4;
    assign o_pixel = r_pixel;

endmodule

`default_nettype wire

// ----- rtl/core/conv3x3_clamped_filter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_clamped_filter_top: 3x3 convolution over a padded pixel stream
// The block takes one padded 8-bit pixel per clock in raster order unless
// held off, and gives one filtered, clamped pixel for every interior
// position, with frame_last on the last one of the frame. A result is
// offered once the pixel that completes its window is accepted and has
// passed the line RAM read, the window update and the products, then the
// running sum and the clamp, and last the write into the result queue.
// Results wait in a 16-entry queue; the input is held off only while 16
// results are in flight or queued, so with the output taking one result per
// clock the input runs at one pixel per clock. The line RAMs need no
// clearing after reset. Kernel and size registers must be written only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module conv3x3_clamped_filter_top #(
    parameter int MAX_INNER = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    c3f_pixel_if.sink           i_pix,
    c3f_result_if.source        o_res,
    c3f_cfg_if.sink             i_cfg
);
    import c3f_pkg::*;

    localparam int LINE_DEPTH = MAX_INNER + 2;
    localparam int IW         = $clog2(LINE_DEPTH);
    localparam int RST_INNER  = (MAX_INNER < SIZE_RESET) ? MAX_INNER : SIZE_RESET;

    // last padded index for a written size, sizes clamped to 1..limit
    function automatic logic [IW-1:0] f_ilast(input logic [SIZE_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > MAX_INNER) n = MAX_INNER;
        return IW'(n + 1);
    endfunction

    function automatic logic [OPOS_W-1:0] f_olast(input logic [SIZE_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > OUTER_LIMIT) n = OUTER_LIMIT;
        return OPOS_W'(n + 1);
    endfunction

    logic [IW-1:0]     r_ilast;
    logic [OPOS_W-1:0] r_olast;
    t_kernel           r_kernel;
    logic [IW-1:0]     r_inner_pos;
    logic [OPOS_W-1:0] r_outer_pos;
    logic [IW-1:0]     w_ip;
    logic [OPOS_W-1:0] w_op;
    logic              w_emit;
    logic              w_last;
    logic              w_acc;
    logic              r_s1_valid;
    logic [IW-1:0]     r_s1_addr;
    logic [PIX_W-1:0]  r_s1_pix;
    logic              r_s1_emit;
    logic              r_s1_last;
    logic [PIX_W-1:0]  w_top;
    logic [PIX_W-1:0]  w_mid;
    t_win              r_win;
    t_win              n_win;
    t_ctl              w_mac_in;
    t_ctl              w_mac_out;
    logic [PIX_W-1:0]  w_mac_pixel;
    t_result           w_push_data;
    t_result           r_fifo [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wptr;
    logic [FPTR_W-1:0] r_rptr;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_pend;
    logic              w_push;
    logic              w_pop;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ilast  <= IW'(RST_INNER + 1);
            r_olast  <= OPOS_W'(SIZE_RESET + 1);
            r_kernel <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_INNER_SIZE:    r_ilast <= f_ilast(i_cfg.data[SIZE_W-1:0]);
                REG_OUTER_SIZE:    r_olast <= f_olast(i_cfg.data[SIZE_W-1:0]);
                REG_KERNEL_TOP:    r_kernel[0] <= i_cfg.data[KROW_W-1:0];
                REG_KERNEL_MID:    r_kernel[1] <= i_cfg.data[KROW_W-1:0];
                REG_KERNEL_BOTTOM: r_kernel[2] <= i_cfg.data[KROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // position of the incoming item, clamped into the current frame
    assign w_ip   = (r_inner_pos > r_ilast) ? r_ilast : r_inner_pos;
    assign w_op   = (r_outer_pos > r_olast) ? r_olast : r_outer_pos;
    assign w_emit = (w_ip >= IW'(BORDER)) && (w_op >= OPOS_W'(BORDER));
    assign w_last = (w_ip == r_ilast) && (w_op == r_olast);

    assign i_pix.ready = (r_pend < CNT_W'(FIFO_DEPTH));
    assign w_acc       = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_pos <= '0;
            r_outer_pos <= '0;
        end else if (w_acc) begin
            if (w_ip == r_ilast) begin
                r_inner_pos <= '0;
                r_outer_pos <= (w_op == r_olast) ? '0 : w_op + OPOS_W'(1);
            end else begin
                r_inner_pos <= w_ip + IW'(1);
                r_outer_pos <= w_op;
            end
        end
    end

    // stage 1: line RAM read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_addr <= w_ip;
            r_s1_pix  <= i_pix.pixel;
            r_s1_emit <= w_emit;
            r_s1_last <= w_last;
        end
    end

    // line RAMs: a holds the row above, b the row two above
    c3f_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_pix),
        .i_re    (w_acc),
        .i_raddr (w_ip),
        .o_rdata (w_mid)
    );

    c3f_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (w_mid),
        .i_re    (w_acc),
        .i_raddr (w_ip),
        .o_rdata (w_top)
    );

    // window shift: columns move left, new column from RAMs and pixel
    always_comb begin
        n_win = r_win;
        if (r_s1_valid) begin
            for (int r = 0; r < KROWS; r++) begin
                for (int c = 0; c < KCOLS - 1; c++) begin
                    n_win[r*KCOLS+c] = r_win[r*KCOLS+c+1];
                end
            end
            n_win[KCOLS-1]         = w_top;
            n_win[2*KCOLS-1]       = w_mid;
            n_win[KROWS*KCOLS-1]   = r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else begin
            r_win <= n_win;
        end
    end

    // kernel datapath
    assign w_mac_in.valid = r_s1_valid && r_s1_emit;
    assign w_mac_in.last  = r_s1_last;

    c3f_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_in),
        .i_win    (n_win),
        .i_kernel (r_kernel),
        .o_ctl    (w_mac_out),
        .o_pixel  (w_mac_pixel)
    );

    // result queue
    assign w_push            = w_mac_out.valid;
    assign w_pop             = o_res.valid && o_res.ready;
    assign w_push_data.pixel = w_mac_pixel;
    assign w_push_data.last  = w_mac_out.last;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wptr] <= w_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + FPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + FPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // results owed: accepted interior items not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if ((w_acc && w_emit) && !w_pop) begin
            r_pend <= r_pend + CNT_W'(1);
        end else if (!(w_acc && w_emit) && w_pop) begin
            r_pend <= r_pend - CNT_W'(1);
        end
    end

    assign o_res.valid      = (r_cnt != '0);
    assign o_res.out_pixel  = r_fifo[r_rptr].pixel;
    assign o_res.frame_last = r_fifo[r_rptr].last;

`ifndef SYNTHESIS
    // owed results never exceed queue space
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= CNT_W'(FIFO_DEPTH))
        else $error("result credit count above queue depth");

    // queued results are a subset of owed results
    a_cnt_le_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_pend)
        else $error("queue holds more results than owed");

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_cnt < CNT_W'(FIFO_DEPTH)) || w_pop)
        else $error("result queue overflow");

    // back-to-back items never touch the same line entry
    a_no_raw_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_acc) |-> (w_ip != r_s1_addr))
        else $error("line RAM read of an entry still being written");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_conv3x3_clamped_filter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv3x3_clamped_filter_top: self-checking bench of the 3x3 clamped filter
// Streams padded frames through the pixel channel under random burst and
// stall patterns, rewrites sizes and kernels between frames, and checks every
// filtered pixel and its frame_last flag against a predictor kept in step
// with the pixels the block accepts.
// ----------------------------------------------------------------------------
module tb_conv3x3_clamped_filter_top;
    import c3f_pkg::*;

    localparam int INNER_MAX     = 1024;
    localparam int LINE_DEPTH    = INNER_MAX + 2;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 12;      // quiet cycles before a register write
    localparam int STALL_LIMIT   = 5000;    // cycles without any accepted item
    localparam int RANDOM_ITEMS  = 1450;
    localparam int MAX_PRINTS    = 40;
    localparam int REG_COUNT     = REG_KERNEL_BOTTOM + 1;
    localparam longint SCALE     = 1 << FRAC_W;
    localparam logic [COEF_W-1:0] COEF_MAX = 16'h7FFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 16'h8000;
    localparam logic [COEF_W-1:0] COEF_NEG_LSB = 16'hFFFF;

    typedef enum logic [1:0] {OP_PIXEL, OP_CFG, OP_DRAIN} t_op_kind;
    typedef enum logic [1:0] {PX_RANDOM, PX_EXTREME, PX_DIM, PX_FULL} t_px_style;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} t_rx_mode;

    typedef struct packed {
        t_op_kind              kind;
        logic [PIX_W-1:0]      pixel;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_op;

    logic i_clk = 1'b0;
    logic i_rst_n;

    c3f_pixel_if  pix_if ();
    c3f_result_if res_if ();
    c3f_cfg_if    cfg_if ();

    conv3x3_clamped_filter_top #(
        .MAX_INNER (INNER_MAX)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // stimulus and expectations
    t_op     pending_ops [$];
    t_result expected_px [$];
    t_result want_px;

    // predictor state
    logic [SIZE_W-1:0] cfg_inner;
    logic [SIZE_W-1:0] cfg_outer;
    logic [KROW_W-1:0] kern_row [KROWS];
    logic [PIX_W-1:0]  line_a [LINE_DEPTH];     // previous padded row
    logic [PIX_W-1:0]  line_b [LINE_DEPTH];     // row before that
    logic [PIX_W-1:0]  win [WIN_TAPS];
    int unsigned       col_pos;
    int unsigned       row_pos;

    // generator view of the sizes, used only to cut frames
    logic [SIZE_W-1:0] gen_inner;
    logic [SIZE_W-1:0] gen_outer;

    int  err_count;
    int  res_count;
    int  idle_cycles;
    bit  pix_took;
    bit  cfg_took;
    bit  res_took;

    function automatic int unsigned eff_size(input logic [SIZE_W-1:0] raw,
                                             input int unsigned hi);
        if (raw == 0) return 1;
        if (raw > hi) return hi;
        return raw;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_word48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return COEF_NEG_LSB;
            3: return 16'($urandom);
            // -0.5 .. +0.75 keeps most sums inside the pixel range
            default: return 16'($urandom_range(0, 320)) - 16'd128;
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] rand_kernel_row();
        if ($urandom_range(0, 4) == 0) return rand_word48();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // one pixel through the line stores and window; queues a result on
    // interior positions
    task automatic predict_filtered_pixel(input logic [PIX_W-1:0] px);
        int unsigned              ilast, olast, ip, op;
        int                       r, c;
        logic [PIX_W-1:0]         top_px, mid_px;
        logic signed [COEF_W-1:0] coef;
        longint                   acc;
        t_result                  res;
        ilast = eff_size(cfg_inner, INNER_MAX) + 1;
        olast = eff_size(cfg_outer, OUTER_LIMIT) + 1;
        ip = (col_pos > ilast) ? ilast : col_pos;
        op = (row_pos > olast) ? olast : row_pos;
        top_px = line_b[ip];
        mid_px = line_a[ip];
        line_b[ip] = mid_px;
        line_a[ip] = px;
        for (r = 0; r < KROWS; r++) begin
            win[r * KCOLS]     = win[r * KCOLS + 1];
            win[r * KCOLS + 1] = win[r * KCOLS + 2];
        end
        win[2] = top_px;
        win[5] = mid_px;
        win[8] = px;
        if (ip >= BORDER && op >= BORDER) begin
            // running sum truncated toward zero after every tap
            acc = 0;
            for (r = 0; r < KROWS; r++) begin
                for (c = 0; c < KCOLS; c++) begin
                    coef = kern_row[r][c * COEF_W +: COEF_W];
                    acc = (acc * SCALE + longint'(win[r * KCOLS + c]) * longint'(coef))
                          / SCALE;
                end
            end
            if (acc > PIX_MAX) acc = PIX_MAX;
            if (acc < 0) acc = 0;
            res.pixel = acc[PIX_W-1:0];
            res.last  = (ip == ilast && op == olast);
            expected_px.insert(expected_px.size(), res);
        end
        if (ip >= ilast) begin
            col_pos = 0;
            row_pos = (op >= olast) ? 0 : op + 1;
        end else begin
            col_pos = ip + 1;
            row_pos = op;
        end
    endtask

    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_INNER_SIZE:    cfg_inner = val[SIZE_W-1:0];
            REG_OUTER_SIZE:    cfg_outer = val[SIZE_W-1:0];
            REG_KERNEL_TOP:    kern_row[0] = val[KROW_W-1:0];
            REG_KERNEL_MID:    kern_row[1] = val[KROW_W-1:0];
            REG_KERNEL_BOTTOM: kern_row[2] = val[KROW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] val);
        t_op op;
        op.kind  = OP_CFG;
        op.pixel = '0;
        op.index = idx;
        op.data  = val;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic push_drain();
        t_op op;
        op       = '0;
        op.kind  = OP_DRAIN;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    // size writes, sometimes with junk above the 11-bit field
    task automatic set_sizes(input logic [SIZE_W-1:0] raw_in,
                             input logic [SIZE_W-1:0] raw_out);
        logic [CFG_DATA_W-1:0] word_in, word_out;
        word_in  = ($urandom_range(0, 3) == 0) ? rand_word48() : '0;
        word_out = ($urandom_range(0, 3) == 0) ? rand_word48() : '0;
        word_in[SIZE_W-1:0]  = raw_in;
        word_out[SIZE_W-1:0] = raw_out;
        push_cfg(REG_INNER_SIZE, word_in);
        push_cfg(REG_OUTER_SIZE, word_out);
        gen_inner = raw_in;
        gen_outer = raw_out;
    endtask

    task automatic set_kernel(input logic [KROW_W-1:0] row_top,
                              input logic [KROW_W-1:0] row_mid,
                              input logic [KROW_W-1:0] row_bot);
        push_cfg(REG_KERNEL_TOP, row_top);
        push_cfg(REG_KERNEL_MID, row_mid);
        push_cfg(REG_KERNEL_BOTTOM, row_bot);
    endtask

    // one whole padded frame, optionally with a full drain somewhere inside
    task automatic push_frame(input t_px_style style, input bit with_pause,
                              output int unsigned n);
        int unsigned k, pause_at;
        t_op         op;
        n = (eff_size(gen_inner, INNER_MAX) + 2) * (eff_size(gen_outer, OUTER_LIMIT) + 2);
        pause_at = with_pause ? $urandom_range(1, n - 1) : n;
        op = '0;
        op.kind = OP_PIXEL;
        for (k = 0; k < n; k++) begin
            if (k == pause_at) push_drain();
            case (style)
                PX_RANDOM:  op.pixel = 8'($urandom);
                PX_EXTREME: op.pixel = $urandom_range(0, 1) ? 8'(PIX_MAX) : 8'd0;
                PX_DIM:     op.pixel = 8'($urandom_range(0, 15));
                default:    op.pixel = 8'(PIX_MAX);
            endcase
            pending_ops.insert(pending_ops.size(), op);
        end
    endtask

    // sampling at the rising edge: prediction, register shadow, result check
    always @(posedge i_clk) begin
        pix_took <= pix_if.valid && pix_if.ready;
        cfg_took <= cfg_if.valid && cfg_if.ready;
        res_took <= res_if.valid && res_if.ready;
        if (i_rst_n) begin
            if (pix_if.valid && pix_if.ready) predict_filtered_pixel(pix_if.pixel);
            if (cfg_if.valid && cfg_if.ready) apply_cfg(cfg_if.index, cfg_if.data);
            if (res_if.valid && res_if.ready) begin
                res_count++;
                if (expected_px.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              res_count));
                end else begin
                    want_px = expected_px.pop_front();
                    if (res_if.out_pixel !== want_px.pixel)
                        report_mismatch($sformatf("result %0d out_pixel %0d, expected %0d",
                                                  res_count, res_if.out_pixel,
                                                  want_px.pixel));
                    if (res_if.frame_last !== want_px.last)
                        report_mismatch($sformatf("result %0d frame_last %0b, expected %0b",
                                                  res_count, res_if.frame_last,
                                                  want_px.last));
                end
            end
        end
    end

    // sender: bursts and gaps for pixels, register writes only when idle
    int gap_left   = 0;
    int burst_left = 1;
    int settle_cnt = 0;

    always @(negedge i_clk) begin : drive_blk
        logic                  pv, cv;
        logic [PIX_W-1:0]      pd;
        logic [CFG_IDX_W-1:0]  ci;
        logic [CFG_DATA_W-1:0] cd;
        pv = pix_if.valid;
        pd = pix_if.pixel;
        cv = cfg_if.valid;
        ci = cfg_if.index;
        cd = cfg_if.data;
        if (i_rst_n) begin
            if (pix_took || cfg_took) void'(pending_ops.pop_front());
            if (pix_took) pv = 1'b0;
            if (cfg_took) cv = 1'b0;
            if (!pv && !cv && pending_ops.size() != 0) begin
                case (pending_ops[0].kind)
                    OP_PIXEL: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            pv = 1'b1;
                            pd = pending_ops[0].pixel;
                            if (burst_left > 1) begin
                                burst_left--;
                            end else begin
                                case ($urandom_range(0, 9))
                                    0: begin            // long run without gaps
                                        burst_left = $urandom_range(100, 300);
                                        gap_left   = 0;
                                    end
                                    1, 2: begin
                                        burst_left = $urandom_range(1, 8);
                                        gap_left   = $urandom_range(5, 20);
                                    end
                                    default: begin
                                        burst_left = $urandom_range(1, 30);
                                        gap_left   = $urandom_range(0, 3);
                                    end
                                endcase
                            end
                        end
                    end
                    OP_CFG: begin
                        // all results in, then the SETTLE_CYCLES wait for the pipeline
                        if (expected_px.size() != 0) begin
                            settle_cnt = 0;
                        end else if (settle_cnt < SETTLE_CYCLES) begin
                            settle_cnt++;
                        end else begin
                            cv = 1'b1;
                            ci = pending_ops[0].index;
                            cd = pending_ops[0].data;
                            settle_cnt = 0;
                        end
                    end
                    default: begin
                        if (expected_px.size() == 0) void'(pending_ops.pop_front());
                    end
                endcase
            end
        end
        pix_if.valid <= pv;
        pix_if.pixel <= pd;
        cfg_if.valid <= cv;
        cfg_if.index <= ci;
        cfg_if.data  <= cd;
    end

    // receiver: changing stall modes plus occasional long hold-offs
    t_rx_mode    rx_mode   = RX_OPEN;
    int          mode_left = 0;
    int          hold_left = 0;
    int unsigned rx_cycle  = 0;

    always @(negedge i_clk) begin : accept_blk
        logic rdy;
        rdy = 1'b1;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (res_took && (res_count % 400) == 150) begin
            // long enough to fill the result queue and stall the input
            hold_left = $urandom_range(150, 250);
            rdy = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = $urandom_range(0, 1);
                RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:   rdy = (rx_cycle % 7) < 4;
            endcase
        end
        rx_cycle++;
        res_if.ready <= rdy;
    end

    // watchdog on cycles in which no channel moves an item
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no item accepted for %0d cycles, %0d results pending",
                     STALL_LIMIT, expected_px.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned fed, n, nframes, f;
        int          r;
        i_rst_n      = 1'b0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        res_if.ready = 1'b0;
        err_count    = 0;
        res_count    = 0;
        idle_cycles  = 0;

        // predictor matches the state after reset
        cfg_inner = SIZE_W'(SIZE_RESET);
        cfg_outer = SIZE_W'(SIZE_RESET);
        for (r = 0; r < KROWS; r++) kern_row[r] = '0;
        for (r = 0; r < LINE_DEPTH; r++) begin
            line_a[r] = '0;
            line_b[r] = '0;
        end
        for (r = 0; r < WIN_TAPS; r++) win[r] = '0;
        col_pos = 0;
        row_pos = 0;

        // directed: reset kernel gives zero, then both clamp limits
        set_sizes(1, 1);
        push_frame(PX_EXTREME, 1'b0, n);
        set_kernel({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}});
        push_frame(PX_FULL, 1'b0, n);
        set_kernel({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}});
        push_frame(PX_FULL, 1'b0, n);

        // zero sizes act as one
        set_sizes(0, 3);
        set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        push_frame(PX_RANDOM, 1'b0, n);
        set_sizes(5, 0);
        set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        push_frame(PX_DIM, 1'b1, n);

        // random phases of one to three frames per register setting
        fed = 0;
        while (fed < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                set_sizes($urandom_range(25, 90), $urandom_range(0, 3));
            else
                set_sizes($urandom_range(0, 24), $urandom_range(0, 10));
            for (r = 0; r < KROWS; r++)
                if ($urandom_range(0, 1))
                    push_cfg(CFG_IDX_W'(REG_KERNEL_TOP + r), rand_kernel_row());
            if ($urandom_range(0, 3) == 0)
                push_cfg(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)),
                         rand_word48());
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++) begin
                push_frame(t_px_style'($urandom_range(0, 3)),
                           $urandom_range(0, 3) == 0, n);
                fed += n;
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || expected_px.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
